@@ rtl/skm_pkg.sv @@
// Shared constants and types for the spectral kurtosis mask unit.
package skm_pkg;

  localparam int CHANNELS     = 1024;
  localparam int MAX_INTERVAL = 256;
  localparam int COUNT_CAP    = (MAX_INTERVAL < 511) ? MAX_INTERVAL : 511;

  localparam int CH_W    = 10;
  localparam int SAMP_W  = 16;
  localparam int SUM_W   = 24;
  localparam int SQ_W    = 40;
  localparam int CNT_W   = 9;
  localparam int Q_W     = 20;
  localparam int TOT_W   = 32;
  localparam int D_W     = 16;
  localparam int ADDR_W  = $clog2(CHANNELS);
  localparam int ENTRY_W = CNT_W + SQ_W + SUM_W;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_AVG   = 2'd0;
  localparam logic [1:0] REG_LOWER = 2'd1;
  localparam logic [1:0] REG_UPPER = 2'd2;

  localparam logic [Q_W-1:0] Q_MAX = {Q_W{1'b1}};

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [SQ_W-1:0]  sq;
    logic [SUM_W-1:0] sum;
  } entry_t;

endpackage

@@ rtl/spectral_kurtosis_mask_unit.sv @@
// Top level of the spectral kurtosis mask unit: per-channel accumulators and SK sequencer.
// Per-channel sums live in one 1024-entry synchronous memory. After reset the unit clears
// every entry of that memory with s_axis_tready low (config writes are still taken).
// A sample that does not close its interval passes through read, accumulate and write back.
// A closing sample then either ends at once with an undefined estimate, stops after the
// multiply steps for a negative or a saturated one, or runs on through the 20-step
// restoring divider that forms the Q8.12 estimate.
// One result register sits at the output, so the next sample is taken while a result waits.
module spectral_kurtosis_mask_unit (
  input  logic        clk,
  input  logic        rst,
  // tdata: channel[9:0], power_sample[25:10], zero above
  input  logic [31:0] s_axis_tdata,
  input  logic        s_axis_tlast,   // interval_end
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: out_channel[9:0], kurtosis_value[29:10], masked_total[61:30], zero above
  output logic [63:0] m_axis_tdata,
  output logic        m_axis_tuser,   // mask_bit
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);
  import skm_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_ACC, ST_SQ, ST_CS2, ST_DEN, ST_SCALE,
    ST_NLO, ST_NHI, ST_DCHK, ST_DIV, ST_FIN
  } state_t;

  state_t state;

  // configuration
  logic [D_W-1:0] avg_factor;
  logic [Q_W-1:0] lower_limit, upper_limit;

  // per-item working registers
  logic [CH_W-1:0]   ch_r;
  logic [SAMP_W-1:0] x_r;
  logic              end_r;
  logic [CNT_W-1:0]  c_r;
  logic [SUM_W-1:0]  s1_r;
  logic [SQ_W-1:0]   s2_r;
  logic [47:0]       s1sq;
  logic [48:0]       diff;
  logic [56:0]       den;
  logic [29:0]       scale;
  logic [78:0]       num;
  logic [76:0]       dsh;
  logic [4:0]        k;
  logic [Q_W-1:0]    q;
  logic              undef;
  logic [TOT_W-1:0]  masked_counter;
  logic [ADDR_W-1:0] clr_addr;

  // memory
  entry_t            mem [0:CHANNELS-1];
  entry_t            rd_data;
  entry_t            wr_data;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  entry_t            acc;

  logic in_fire, out_free, mask_now, ch_ok;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign ch_ok         = (32'(s_axis_tdata[CH_W-1:0]) < CHANNELS);

  // accumulate the new sample onto the stored entry
  always_comb begin
    acc = rd_data;
    if (32'(rd_data.count) < COUNT_CAP) begin
      acc.sum   = rd_data.sum + SUM_W'(x_r);
      acc.sq    = rd_data.sq + SQ_W'(32'(x_r) * 32'(x_r));
      acc.count = rd_data.count + CNT_W'(1);
    end
  end

  // memory write port: clearing pass or write-back
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ch_r[ADDR_W-1:0];
    wr_data = acc;
    if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else if (state == ST_ACC) begin
      wr_en = 1'b1;
      if (end_r) wr_data = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[ch_r[ADDR_W-1:0]];
  end

  // mask decision on the final quotient; after a division num holds the remainder
  assign mask_now = undef || (q < lower_limit) || (q > upper_limit) ||
                    ((q == upper_limit) && (num != '0));

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      avg_factor  <= D_W'(512);
      lower_limit <= Q_W'(3277);
      upper_limit <= Q_W'(5120);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_AVG:   avg_factor  <= cfg_data[D_W-1:0];
        REG_LOWER: lower_limit <= cfg_data;
        REG_UPPER: upper_limit <= cfg_data;
        default:   ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_addr       <= '0;
      masked_counter <= '0;
      m_axis_tvalid  <= 1'b0;
    end else begin
      // the finish state reloads the output itself when it is free
      if (m_axis_tvalid && m_axis_tready && state != ST_FIN) m_axis_tvalid <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (32'(clr_addr) == CHANNELS - 1) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_fire && ch_ok) begin
            ch_r  <= s_axis_tdata[CH_W-1:0];
            x_r   <= s_axis_tdata[CH_W+SAMP_W-1:CH_W];
            end_r <= s_axis_tlast;
            state <= ST_READ;
          end
        end
        ST_READ: state <= ST_ACC;
        ST_ACC: begin
          c_r   <= acc.count;
          s1_r  <= acc.sum;
          s2_r  <= acc.sq;
          q     <= '0;
          undef <= 1'b1;
          if (!end_r) begin
            state <= ST_IDLE;
          end else if (acc.count < CNT_W'(2) || acc.sum == '0) begin
            state <= ST_FIN;
          end else begin
            undef <= 1'b0;
            state <= ST_SQ;
          end
        end
        ST_SQ: begin
          s1sq  <= 48'(s1_r) * 48'(s1_r);
          state <= ST_CS2;
        end
        ST_CS2: begin
          diff  <= 49'(c_r) * 49'(s2_r);
          state <= ST_DEN;
        end
        ST_DEN: begin
          if (diff < 49'(s1sq)) begin
            undef <= 1'b1;
            state <= ST_FIN;
          end else begin
            diff  <= diff - 49'(s1sq);
            den   <= 57'(c_r - CNT_W'(1)) * 57'(s1sq);
            state <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          scale <= 30'({(26'(c_r) * 26'(avg_factor)) + 26'(256), 4'b0000});
          state <= ST_NLO;
        end
        ST_NLO: begin
          num   <= 79'(55'(scale) * 55'(diff[24:0]));
          state <= ST_NHI;
        end
        ST_NHI: begin
          num   <= num + {54'(scale) * 54'(diff[48:25]), 25'b0};
          state <= ST_DCHK;
        end
        ST_DCHK: begin
          if (num >= 79'({den, 20'b0})) begin
            q     <= Q_MAX;
            state <= ST_FIN;
          end else begin
            dsh   <= {1'b0, den, 19'b0};
            k     <= 5'd19;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (num >= 79'(dsh)) begin
            num  <= num - 79'(dsh);
            q[k] <= 1'b1;
          end
          dsh <= dsh >> 1;
          k   <= k - 5'd1;
          if (k == 5'd0) state <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser  <= mask_now;
            m_axis_tdata  <= {2'b00, masked_counter + TOT_W'(mask_now), q, ch_r};
            if (mask_now) masked_counter <= masked_counter + TOT_W'(1);
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/skm_checker.sv @@
// Port-level checks for the spectral kurtosis mask unit, bound to the top level.
module skm_port_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready
);

  // reset starts the clearing pass: no input taken, no result shown
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !s_axis_tready && !m_axis_tvalid)
    else $error("input or output active right after reset");

  // one request in work at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request taken while one is in work");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind spectral_kurtosis_mask_unit skm_port_checker u_skm_port_checker (
  .clk(clk), .rst(rst),
  .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready)
);
